// ----- rtl/credit_max_thread_scheduler_top_assert.svh -----
// Assertion macros for the credit scheduler.
`ifndef CREDIT_MAX_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define CREDIT_MAX_THREAD_SCHEDULER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CMTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("credit scheduler check failed");
`define CMTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("credit scheduler check failed");
`else
`define CMTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CMTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/cmts_pkg.sv -----
package cmts_pkg;

  localparam int IDX_MAX_W  = 8;
  localparam int PRIO_MAX_W = 16;
  localparam int CRED_W     = PRIO_MAX_W + 1;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_SLEEP  = 3'd1;
  localparam logic [2:0] CMD_WAKE   = 3'd2;
  localparam logic [2:0] CMD_LOAD   = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;

  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_TICK     = 3'd1;
  localparam logic [2:0] OP_TICK_DEC = 3'd2;
  localparam logic [2:0] OP_SLEEP    = 3'd3;
  localparam logic [2:0] OP_WAKE     = 3'd4;
  localparam logic [2:0] OP_LOAD     = 3'd5;
  localparam logic [2:0] OP_REMOVE   = 3'd6;
  localparam logic [2:0] OP_RELOAD   = 3'd7;

  typedef struct packed {
    logic [2:0]            op;
    logic [IDX_MAX_W-1:0]  target;
    logic [PRIO_MAX_W-1:0] prio;
  } cell_cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [IDX_MAX_W-1:0] idx;
    logic [CRED_W-1:0]    credit;
    logic [CRED_W-1:0]    reload;
  } scan_tok_t;

  typedef struct packed {
    logic              present;
    logic              running;
    logic [CRED_W-1:0] credit;
    logic [CRED_W-1:0] reload;
  } cell_stat_t;

endpackage

// ----- rtl/credit_max_thread_scheduler_top.sv -----
// Flow: commands without a scan go from idle to FIN and then to the output register;
// a scan passes START1 and SCAN1, a scan with credit reload also START2 and SCAN2, before FIN.
// The scan token walks the slot cell chain one cell per cycle; FIN waits while the output is stalled.
// One command is in work at a time; a new one is taken once the previous is finished.
// Synchronous active-low reset: slot 0 present and running, all credits zero,
// current slot 0, tick count 0, max_reentry 1.
`include "credit_max_thread_scheduler_top_assert.svh"

module credit_max_thread_scheduler_top #(
  parameter int NUM_SLOTS = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_slot,
  input  logic [7:0]  in_reentry_depth,
  input  logic [7:0]  in_priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_current_slot,
  output logic        out_switched,
  output logic        out_scheduled,
  output logic [31:0] out_tick_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int CRED_W = cmts_pkg::CRED_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START1 = 3'd1;
  localparam logic [2:0] ST_SCAN1  = 3'd2;
  localparam logic [2:0] ST_START2 = 3'd3;
  localparam logic [2:0] ST_SCAN2  = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  running_slot_r, running_slot_nxt;
  logic [31:0]       tick_total_r, tick_total_nxt;
  logic [7:0]        max_reentry_r, max_reentry_nxt;
  logic              sw_r, sw_nxt;
  logic              sc_r, sc_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CRED_W-1:0] best_reload_r, best_reload_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_slot_r;
  logic              out_sw_r;
  logic              out_sc_r;
  logic [31:0]       out_tick_r;
  logic              out_load;

  cmts_pkg::cell_cmd_t  cell_cmd;
  cmts_pkg::scan_tok_t  tok_head;
  cmts_pkg::scan_tok_t  tok [NUM_SLOTS+1];
  cmts_pkg::cell_stat_t stat [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] present_vec;
  logic [NUM_SLOTS-1:0] running_vec;

  logic [IDX_W-1:0] slot_idx;
  logic             in_range;
  logic             tgt_present;
  logic             tgt_running;
  logic [IDX_W-1:0] win_idx;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      cmts_cell #(
        .PRIO_BITS (PRIO_BITS),
        .IDX       (gi)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_i  (cell_cmd),
        .tok_i  (tok[gi]),
        .tok_o  (tok[gi+1]),
        .stat_o (stat[gi])
      );
      assign present_vec[gi] = stat[gi].present;
      assign running_vec[gi] = stat[gi].running;
    end
  endgenerate

  assign tok[0]      = tok_head;
  assign slot_idx    = IDX_W'(in_slot);
  assign in_range    = (32'(in_slot) < NUM_SLOTS);
  assign tgt_present = in_range && present_vec[slot_idx];
  assign tgt_running = in_range && running_vec[slot_idx];
  assign win_idx     = IDX_W'(tok[NUM_SLOTS].idx);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt        = state_r;
    running_slot_nxt = running_slot_r;
    tick_total_nxt   = tick_total_r;
    max_reentry_nxt  = max_reentry_r;
    sw_nxt           = sw_r;
    sc_nxt           = sc_r;
    best_idx_nxt     = best_idx_r;
    best_reload_nxt  = best_reload_r;
    out_valid_nxt    = out_valid_r && out_stall;
    cell_cmd.op      = cmts_pkg::OP_NONE;
    cell_cmd.target  = cmts_pkg::IDX_MAX_W'(in_slot);
    cell_cmd.prio    = cmts_pkg::PRIO_MAX_W'(in_priority_req);
    tok_head         = '0;

    if (cfg_valid && cfg_ready) begin
      max_reentry_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sw_nxt    = 1'b0;
          sc_nxt    = 1'b0;
          state_nxt = ST_FIN;
          case (in_cmd)
            cmts_pkg::CMD_TICK: begin
              tick_total_nxt  = tick_total_r + 32'd1;
              cell_cmd.target = cmts_pkg::IDX_MAX_W'(running_slot_r);
              if (in_reentry_depth <= max_reentry_r) begin
                cell_cmd.op = cmts_pkg::OP_TICK_DEC;
                sc_nxt      = 1'b1;
                state_nxt   = ST_START1;
              end else begin
                cell_cmd.op = cmts_pkg::OP_TICK;
              end
            end
            cmts_pkg::CMD_SLEEP: begin
              if (tgt_present && tgt_running) begin
                cell_cmd.op = cmts_pkg::OP_SLEEP;
                sc_nxt      = 1'b1;
                state_nxt   = ST_START1;
              end
            end
            cmts_pkg::CMD_WAKE: begin
              if (tgt_present && !tgt_running) begin
                cell_cmd.op      = cmts_pkg::OP_WAKE;
                sw_nxt           = (slot_idx != running_slot_r);
                running_slot_nxt = slot_idx;
              end
            end
            cmts_pkg::CMD_LOAD: begin
              if (in_range) begin
                cell_cmd.op = cmts_pkg::OP_LOAD;
              end
            end
            cmts_pkg::CMD_REMOVE: begin
              if (in_range && (in_slot != 4'd0)) begin
                cell_cmd.op = cmts_pkg::OP_REMOVE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_START1: begin
        tok_head.valid  = 1'b1;
        tok_head.idx    = '0;
        tok_head.credit = stat[0].credit;
        tok_head.reload = stat[0].reload;
        state_nxt       = ST_SCAN1;
      end
      ST_SCAN1: begin
        if (tok[NUM_SLOTS].valid) begin
          if (tok[NUM_SLOTS].credit[CRED_W-1] || (tok[NUM_SLOTS].credit == '0)) begin
            cell_cmd.op     = cmts_pkg::OP_RELOAD;
            best_idx_nxt    = win_idx;
            best_reload_nxt = tok[NUM_SLOTS].reload;
            state_nxt       = ST_START2;
          end else begin
            sw_nxt           = (win_idx != running_slot_r);
            running_slot_nxt = win_idx;
            state_nxt        = ST_FIN;
          end
        end
      end
      ST_START2: begin
        tok_head.valid  = 1'b1;
        tok_head.idx    = cmts_pkg::IDX_MAX_W'(best_idx_r);
        tok_head.credit = best_reload_r;
        tok_head.reload = best_reload_r;
        state_nxt       = ST_SCAN2;
      end
      ST_SCAN2: begin
        if (tok[NUM_SLOTS].valid) begin
          sw_nxt           = (win_idx != running_slot_r);
          running_slot_nxt = win_idx;
          state_nxt        = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      running_slot_r <= '0;
      tick_total_r   <= '0;
      max_reentry_r  <= 8'd1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      running_slot_r <= running_slot_nxt;
      tick_total_r   <= tick_total_nxt;
      max_reentry_r  <= max_reentry_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_r          <= sw_nxt;
    sc_r          <= sc_nxt;
    best_idx_r    <= best_idx_nxt;
    best_reload_r <= best_reload_nxt;
    if (out_load) begin
      out_slot_r <= 4'(running_slot_r);
      out_sw_r   <= sw_r;
      out_sc_r   <= sc_r;
      out_tick_r <= tick_total_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_current_slot = out_slot_r;
  assign out_switched     = out_sw_r;
  assign out_scheduled    = out_sc_r;
  assign out_tick_count   = out_tick_r;

  `CMTS_ASSERT_IMP(a_running_in_range, clk, rst_n, 1'b1, (32'(running_slot_r) < NUM_SLOTS))
  `CMTS_ASSERT_IMP(a_scan_end_in_scan, clk, rst_n, tok[NUM_SLOTS].valid, (state_r == ST_SCAN1 || state_r == ST_SCAN2))
  `CMTS_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, (in_valid && !in_stall), (state_r != ST_IDLE))

endmodule

// ----- rtl/cmts_cell.sv -----
module cmts_cell #(
  parameter int PRIO_BITS = 8,
  parameter int IDX       = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmts_pkg::cell_cmd_t    cmd_i,
  input  cmts_pkg::scan_tok_t    tok_i,
  output cmts_pkg::scan_tok_t    tok_o,
  output cmts_pkg::cell_stat_t   stat_o
);

  logic                        present_r;
  logic                        running_r;
  logic [PRIO_BITS-1:0]        prio_r;
  logic signed [PRIO_BITS:0]   credit_r;
  logic                        present_nxt;
  logic                        running_nxt;
  logic [PRIO_BITS-1:0]        prio_nxt;
  logic signed [PRIO_BITS:0]   credit_nxt;
  logic [cmts_pkg::CRED_W-1:0] credit_ext;
  logic [cmts_pkg::CRED_W-1:0] prio_ext;
  logic                        hit;
  logic                        take;
  cmts_pkg::scan_tok_t         tok_r;
  cmts_pkg::scan_tok_t         tok_nxt;

  assign credit_ext = cmts_pkg::CRED_W'(credit_r);
  assign prio_ext   = cmts_pkg::CRED_W'(prio_r);
  assign hit        = (cmd_i.target == cmts_pkg::IDX_MAX_W'(IDX));

  always_comb begin
    present_nxt = present_r;
    running_nxt = running_r;
    prio_nxt    = prio_r;
    credit_nxt  = credit_r;
    case (cmd_i.op) inside
      cmts_pkg::OP_TICK, cmts_pkg::OP_WAKE: begin
        if (hit) begin
          running_nxt = 1'b1;
        end
      end
      cmts_pkg::OP_TICK_DEC: begin
        if (hit) begin
          running_nxt = 1'b1;
          if (!credit_r[PRIO_BITS]) begin
            credit_nxt = credit_r - (PRIO_BITS + 1)'(1);
          end
        end
      end
      cmts_pkg::OP_SLEEP: begin
        if (hit) begin
          running_nxt = 1'b0;
        end
      end
      cmts_pkg::OP_LOAD: begin
        if (hit) begin
          present_nxt = 1'b1;
          running_nxt = 1'b1;
          prio_nxt    = cmd_i.prio[PRIO_BITS-1:0];
          credit_nxt  = {1'b0, cmd_i.prio[PRIO_BITS-1:0]};
        end
      end
      cmts_pkg::OP_REMOVE: begin
        if (hit) begin
          present_nxt = 1'b0;
          running_nxt = 1'b0;
          prio_nxt    = '0;
          credit_nxt  = '0;
        end
      end
      cmts_pkg::OP_RELOAD: begin
        if (present_r) begin
          credit_nxt = {1'b0, prio_r};
        end
      end
      default: begin
      end
    endcase
  end

  // The scan token picks up this slot when it is present and running and holds a strictly greater credit.
  assign take = tok_i.valid && present_r && running_r &&
                ($signed(credit_ext) > $signed(tok_i.credit));

  always_comb begin
    tok_nxt = tok_i;
    if (take) begin
      tok_nxt.idx    = cmts_pkg::IDX_MAX_W'(IDX);
      tok_nxt.credit = credit_ext;
      tok_nxt.reload = prio_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= (IDX == 0);
      running_r <= (IDX == 0);
      prio_r    <= '0;
      credit_r  <= '0;
      tok_r     <= '0;
    end else begin
      present_r <= present_nxt;
      running_r <= running_nxt;
      prio_r    <= prio_nxt;
      credit_r  <= credit_nxt;
      tok_r     <= tok_nxt;
    end
  end

  assign tok_o          = tok_r;
  assign stat_o.present = present_r;
  assign stat_o.running = running_r;
  assign stat_o.credit  = credit_ext;
  assign stat_o.reload  = present_r ? prio_ext : credit_ext;

endmodule
